@@ hdl/small_matrix_inverse_det_unit_macros.svh @@
`ifndef SMALL_MATRIX_INVERSE_DET_UNIT_MACROS_SVH
`define SMALL_MATRIX_INVERSE_DET_UNIT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define SMID_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Signal equals another one sampled a fixed number of edges earlier; history
// from before time zero counts as low.
`define SMID_ASSERT_DELAYED(lbl, sig, src, lat, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) \
    (sig) == ($past(src, lat) === 1'b1)) \
    else $error(msg);

`endif

@@ hdl/smid_pkg.sv @@
`default_nettype none
package smid_pkg;

  localparam int EW        = 32;
  localparam int PW        = 2 * EW;
  localparam int CW        = PW + 1;
  localparam int DW        = 98;
  localparam int QW        = 32;
  localparam int DIV_STEPS = QW;
  localparam int NE        = 9;

  localparam logic [1:0] SIZE_ONE   = 2'd1;
  localparam logic [1:0] SIZE_TWO   = 2'd2;
  localparam logic [1:0] SIZE_THREE = 2'd3;

  typedef logic [3:0] idx_t;

  // cofactor k = e[MA]*e[MB] - e[MC]*e[MD], entries in column-major order
  localparam idx_t MA [NE] = '{4'd4, 4'd2, 4'd1, 4'd6, 4'd0, 4'd3, 4'd3, 4'd6, 4'd0};
  localparam idx_t MB [NE] = '{4'd8, 4'd7, 4'd5, 4'd5, 4'd8, 4'd2, 4'd7, 4'd1, 4'd4};
  localparam idx_t MC [NE] = '{4'd7, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd6, 4'd0, 4'd3};
  localparam idx_t MD [NE] = '{4'd5, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd4, 4'd7, 4'd1};

  typedef struct packed {
    logic signed [EW-1:0] m_r1c1;
    logic signed [EW-1:0] m_r2c1;
    logic signed [EW-1:0] m_r3c1;
    logic signed [EW-1:0] m_r1c2;
    logic signed [EW-1:0] m_r2c2;
    logic signed [EW-1:0] m_r3c2;
    logic signed [EW-1:0] m_r1c3;
    logic signed [EW-1:0] m_r2c3;
    logic signed [EW-1:0] m_r3c3;
    logic                 last_matrix;
  } matrix_t;

  typedef struct packed {
    logic signed [QW-1:0] determinant;
    logic signed [QW-1:0] inv_r1c1;
    logic signed [QW-1:0] inv_r2c1;
    logic signed [QW-1:0] inv_r3c1;
    logic signed [QW-1:0] inv_r1c2;
    logic signed [QW-1:0] inv_r2c2;
    logic signed [QW-1:0] inv_r3c2;
    logic signed [QW-1:0] inv_r1c3;
    logic signed [QW-1:0] inv_r2c3;
    logic signed [QW-1:0] inv_r3c3;
    logic                 status;
    logic                 last_out;
  } result_t;

endpackage
`default_nettype wire

@@ hdl/smid_div.sv @@
`default_nettype none
module smid_div (
  input  wire logic                       clk,
  input  wire logic [smid_pkg::CW-1:0]    num,
  input  wire logic [smid_pkg::DW-1:0]    den,
  output logic      [smid_pkg::QW-1:0]    quo,
  output logic                            ovf
);
  import smid_pkg::*;

  logic [DW-1:0] rem  [0:DIV_STEPS];
  logic [DW-1:0] dd   [0:DIV_STEPS];
  logic [QW-1:0] qq   [0:DIV_STEPS];
  logic          ov   [0:DIV_STEPS];
  logic [DW:0]   trial[0:DIV_STEPS-1];
  logic          ge   [0:DIV_STEPS-1];

  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial[k] = {rem[k], 1'b0};
      ge[k]    = trial[k] >= {1'b0, dd[k]};
    end
  end

  always_ff @(posedge clk) begin
    rem[0] <= DW'(num);
    dd[0]  <= den;
    qq[0]  <= '0;
    ov[0]  <= DW'(num) >= den;
    for (int k = 0; k < DIV_STEPS; k++) begin
      rem[k+1] <= ge[k] ? DW'(trial[k] - {1'b0, dd[k]}) : trial[k][DW-1:0];
      dd[k+1]  <= dd[k];
      qq[k+1]  <= {qq[k][QW-2:0], ge[k]};
      ov[k+1]  <= ov[k];
    end
  end

  assign quo = qq[DIV_STEPS];
  assign ovf = ov[DIV_STEPS];

endmodule
`default_nettype wire

@@ hdl/small_matrix_inverse_det_unit.sv @@
`default_nettype none
// Determinant and inverse of a 1x1, 2x2 or 3x3 matrix, signed Q16.16.
// Input: raise start with a column-major matrix on matrix; it is taken at
// every edge where start is high and busy is low. busy is high only in reset,
// so one matrix per clock is taken, back to back.
// Output: done pulses for one cycle with the result on result; the receiver
// cannot stall, so results leave in input order, one per matrix.
// Pipeline: seven stages of products, cofactors and determinant, then a
// 33-stage restoring divider (an overflow check, then one quotient bit per
// stage, nine dividers side by side), then the output register.
// Throughput: one matrix per clock.
// Configuration: cfg_data (matrix size) is written when cfg_valid is high;
// cfg_ready is always high. Write it only with the pipeline empty. Size zero
// acts as size one.
// Reset: synchronous, clears all valid bits and sets the size to three.
// A zero determinant gives status one and all values zero.
`include "small_matrix_inverse_det_unit_macros.svh"
module small_matrix_inverse_det_unit (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire smid_pkg::matrix_t matrix,
  output logic                   done,
  output smid_pkg::result_t      result,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_data
);
  import smid_pkg::*;

  localparam int LATENCY = DIV_STEPS + 9;
  localparam logic [1:0] ROW_OF [NE] = '{2'd1, 2'd2, 2'd3, 2'd1, 2'd2, 2'd3, 2'd1, 2'd2, 2'd3};
  localparam logic [1:0] COL_OF [NE] = '{2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd3, 2'd3, 2'd3};

  typedef struct packed {
    logic          last;
    logic [1:0]    sz;
    logic          zero;
    logic [QW-1:0] det;
    logic [NE-1:0] qneg;
  } side_t;

  function automatic logic [QW-1:0] sat32(input logic [DW-1:0] m, input logic neg);
    logic [QW-1:0] lim;
    logic [QW-1:0] v;
    lim = neg ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
    v   = ((|m[DW-1:QW]) || (m[QW-1:0] > lim)) ? lim : m[QW-1:0];
    return neg ? QW'(-v) : v;
  endfunction

  logic [1:0] size_reg;
  logic       accept;

  assign busy      = rst;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_reg <= SIZE_THREE;
    end else if (cfg_valid && cfg_ready) begin
      size_reg <= cfg_data;
    end
  end

  // stage 1: input register
  logic signed [EW-1:0] e1 [NE];
  logic                 last1, v1;
  logic [1:0]           sz1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= accept;
    e1[0] <= matrix.m_r1c1;
    e1[1] <= matrix.m_r2c1;
    e1[2] <= matrix.m_r3c1;
    e1[3] <= matrix.m_r1c2;
    e1[4] <= matrix.m_r2c2;
    e1[5] <= matrix.m_r3c2;
    e1[6] <= matrix.m_r1c3;
    e1[7] <= matrix.m_r2c3;
    e1[8] <= matrix.m_r3c3;
    last1 <= matrix.last_matrix;
    sz1   <= (size_reg == 2'd0) ? SIZE_ONE : size_reg;
  end

  // stage 2: minor products
  logic signed [PW-1:0] pa2 [NE];
  logic signed [PW-1:0] pc2 [NE];
  logic signed [EW-1:0] e2  [NE];
  logic                 last2, v2;
  logic [1:0]           sz2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
    for (int k = 0; k < NE; k++) begin
      pa2[k] <= PW'(e1[MA[k]]) * PW'(e1[MB[k]]);
      pc2[k] <= PW'(e1[MC[k]]) * PW'(e1[MD[k]]);
      e2[k]  <= e1[k];
    end
    last2 <= last1;
    sz2   <= sz1;
  end

  // stage 3: cofactors by size
  logic signed [CW-1:0] minor [NE];
  logic signed [CW-1:0] cof_next [NE];
  logic signed [CW-1:0] cof3 [NE];
  logic signed [EW-1:0] r13 [3];
  logic signed [DW-1:0] dsm3;
  logic                 last3, v3;
  logic [1:0]           sz3;

  always_comb begin
    for (int k = 0; k < NE; k++) begin
      minor[k]    = CW'(pa2[k]) - CW'(pc2[k]);
      cof_next[k] = '0;
    end
    case (sz2)
      SIZE_THREE: begin
        for (int k = 0; k < NE; k++) cof_next[k] = minor[k];
      end
      SIZE_TWO: begin
        cof_next[0] = CW'(e2[4]);
        cof_next[1] = -CW'(e2[1]);
        cof_next[3] = -CW'(e2[3]);
        cof_next[4] = CW'(e2[0]);
      end
      default: begin
        cof_next[0] = CW'(1);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else     v3 <= v2;
    for (int k = 0; k < NE; k++) cof3[k] <= cof_next[k];
    r13[0] <= e2[0];
    r13[1] <= e2[3];
    r13[2] <= e2[6];
    dsm3   <= (sz2 == SIZE_TWO) ? DW'(minor[8]) : DW'(e2[0]);
    last3  <= last2;
    sz3    <= sz2;
  end

  // stage 4: partial products of the first-row expansion
  logic signed [CW-1:0] pl4 [3];
  logic signed [CW-1:0] ph4 [3];
  logic signed [CW-1:0] cof4 [NE];
  logic signed [DW-1:0] dsm4;
  logic                 last4, v4;
  logic [1:0]           sz4;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else     v4 <= v3;
    for (int j = 0; j < 3; j++) begin
      pl4[j] <= CW'(r13[j]) * CW'($signed({1'b0, cof3[j][31:0]}));
      ph4[j] <= CW'(r13[j]) * CW'($signed(cof3[j][CW-1:32]));
    end
    for (int k = 0; k < NE; k++) cof4[k] <= cof3[k];
    dsm4  <= dsm3;
    last4 <= last3;
    sz4   <= sz3;
  end

  // stage 5: combine partial products
  logic signed [DW-1:0] t5 [3];
  logic signed [CW-1:0] cof5 [NE];
  logic signed [DW-1:0] dsm5;
  logic                 last5, v5;
  logic [1:0]           sz5;

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else     v5 <= v4;
    for (int j = 0; j < 3; j++) t5[j] <= (DW'(ph4[j]) <<< 32) + DW'(pl4[j]);
    for (int k = 0; k < NE; k++) cof5[k] <= cof4[k];
    dsm5  <= dsm4;
    last5 <= last4;
    sz5   <= sz4;
  end

  // stage 6: determinant
  logic signed [DW-1:0] det6;
  logic signed [CW-1:0] cof6 [NE];
  logic                 last6, v6;
  logic [1:0]           sz6;

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else     v6 <= v5;
    det6 <= (sz5 == SIZE_THREE) ? t5[0] + t5[1] + t5[2] : dsm5;
    for (int k = 0; k < NE; k++) cof6[k] <= cof5[k];
    last6 <= last5;
    sz6   <= sz5;
  end

  // stage 7: magnitudes and signs
  logic [DW-1:0] mag7;
  logic          dneg7, zero7;
  logic [CW-1:0] cmag7 [NE];
  logic [NE-1:0] cneg7;
  logic          last7, v7;
  logic [1:0]    sz7;

  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else     v7 <= v6;
    dneg7 <= det6[DW-1];
    zero7 <= det6 == '0;
    mag7  <= det6[DW-1] ? DW'(-det6) : DW'(det6);
    for (int k = 0; k < NE; k++) begin
      cneg7[k] <= cof6[k][CW-1];
      cmag7[k] <= cof6[k][CW-1] ? CW'(-cof6[k]) : CW'(cof6[k]);
    end
    last7 <= last6;
    sz7   <= sz6;
  end

  // quotient pipeline
  logic [QW-1:0] quo [NE];
  logic          ovf [NE];

  for (genvar g = 0; g < NE; g++) begin : g_div
    smid_div u_div (
      .clk (clk),
      .num (cmag7[g]),
      .den (mag7),
      .quo (quo[g]),
      .ovf (ovf[g])
    );
  end

  logic [DW-1:0] det_shift;
  side_t         side_next;
  side_t         side   [0:DIV_STEPS];
  logic          side_v [0:DIV_STEPS];

  always_comb begin
    case (sz7)
      SIZE_THREE: det_shift = mag7 >> 32;
      SIZE_TWO:   det_shift = mag7 >> 16;
      default:    det_shift = mag7;
    endcase
    side_next.last = last7;
    side_next.sz   = sz7;
    side_next.zero = zero7;
    side_next.det  = sat32(det_shift, dneg7);
    side_next.qneg = cneg7 ^ {NE{dneg7}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= DIV_STEPS; k++) side_v[k] <= 1'b0;
    end else begin
      side_v[0] <= v7;
      for (int k = 0; k < DIV_STEPS; k++) side_v[k+1] <= side_v[k];
    end
    side[0] <= side_next;
    for (int k = 0; k < DIV_STEPS; k++) side[k+1] <= side[k];
  end

  // output stage
  side_t         fin;
  logic [QW-1:0] inv [NE];
  result_t       result_next;
  logic [1:0]    out_sz;

  always_comb begin
    fin = side[DIV_STEPS];
    for (int k = 0; k < NE; k++) begin
      if (!fin.zero && ROW_OF[k] <= fin.sz && COL_OF[k] <= fin.sz) begin
        inv[k] = sat32(ovf[k] ? '1 : DW'(quo[k]), fin.qneg[k]);
      end else begin
        inv[k] = '0;
      end
    end
    result_next.determinant = fin.zero ? '0 : fin.det;
    result_next.inv_r1c1    = inv[0];
    result_next.inv_r2c1    = inv[1];
    result_next.inv_r3c1    = inv[2];
    result_next.inv_r1c2    = inv[3];
    result_next.inv_r2c2    = inv[4];
    result_next.inv_r3c2    = inv[5];
    result_next.inv_r1c3    = inv[6];
    result_next.inv_r2c3    = inv[7];
    result_next.inv_r3c3    = inv[8];
    result_next.status      = fin.zero;
    result_next.last_out    = fin.last;
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= side_v[DIV_STEPS];
    result <= result_next;
    out_sz <= fin.sz;
  end

  `SMID_ASSERT_DELAYED(a_one_result_per_transaction, done, accept, LATENCY, "result strobe out of step with accepted transactions")
  `SMID_ASSERT_IMPLIES(a_singular_cleared, done && result.status, result.determinant == '0 && result.inv_r1c1 == '0 && result.inv_r2c2 == '0, "singular result not cleared")
  `SMID_ASSERT_IMPLIES(a_inactive_zero, done && out_sz != SIZE_THREE, result.inv_r3c3 == '0 && result.inv_r1c3 == '0 && result.inv_r3c1 == '0, "inactive inverse entry not zero")

endmodule
`default_nettype wire
